// ===== rtl/voc_pkg.sv =====
`timescale 1ns / 1ps
package voc_pkg;

  localparam logic [31:0] HASH_MIX = 32'h9e37_79b9;
  localparam int TABLE_ENTRIES = 1024;

  typedef enum logic [2:0] {
    MODE_FREE  = 3'd0,
    MODE_OCC   = 3'd1,
    MODE_DYN   = 3'd2,
    MODE_QUERY = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WAIT,
    ST_HASH,
    ST_RD,
    ST_CMP,
    ST_UPD,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic hash;
    logic rd;
    logic step;
    logic wr;
    logic clr;
    logic res;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic last_axis;
    logic hit;
    logic empty;
    logic exhausted;
    logic clr_done;
  } sts_t;

endpackage

// ===== rtl/voxel_occupancy_cell_store.sv =====
`timescale 1ns / 1ps
// Three serial key divisions, one per axis, come before the hash; a voxel is found
// or inserted at its home slot or at a further probed slot. One item at a time:
// a new input is taken only after the result of the last is loaded for output,
// and the serial divider sets the rate. Clear-all gives a result after its sweep.
// Reset is synchronous, active low; after reset, and for each clear-all, a sweep
// zeroes the table one entry per cycle with in_tready low.
module voxel_occupancy_cell_store #(
  parameter int COUNT_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode[2:0], pos_x[34:3], pos_y[66:35], pos_z[98:67], time_stamp[130:99]
  input  logic [135:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_state[1:0], table_full[2]
  output logic [7:0]  out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import voc_pkg::*;

  localparam logic [3:0] A_VSIZE = 4'd0;
  localparam logic [3:0] A_OTHR  = 4'd4;
  localparam logic [3:0] A_FTHR  = 4'd8;
  localparam logic [3:0] A_LIFE  = 4'd12;

  logic [30:0] vsize_r;
  logic [15:0] othr_r, fthr_r;
  logic [31:0] life_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsize_r <= 31'd6554; othr_r <= 16'd3; fthr_r <= 16'd3; life_r <= 32'd1000;
    end else if (wr_en) begin
      unique case (cfg_paddr)
        A_VSIZE: vsize_r <= cfg_pwdata[30:0];
        A_OTHR:  othr_r  <= cfg_pwdata[15:0];
        A_FTHR:  fthr_r  <= cfg_pwdata[15:0];
        A_LIFE:  life_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      A_VSIZE: cfg_prdata = {1'b0, vsize_r};
      A_OTHR:  cfg_prdata = {16'd0, othr_r};
      A_FTHR:  cfg_prdata = {16'd0, fthr_r};
      A_LIFE:  cfg_prdata = life_r;
      default: cfg_prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;
  logic in_fire, out_load, ready;
  logic [1:0] st;
  logic full;
  logic ovalid_r;
  logic [2:0] odata_r;

  assign in_tready = ready;
  assign in_fire   = in_tvalid && ready;

  voc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_mode(in_tdata[2:0]),
    .out_busy(ovalid_r), .out_taken(out_tready), .sts(sts), .cmd(cmd),
    .in_ready(ready), .out_load(out_load)
  );

  voc_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .mode(in_tdata[2:0]),
    .pos_x(in_tdata[34:3]), .pos_y(in_tdata[66:35]), .pos_z(in_tdata[98:67]),
    .time_stamp(in_tdata[130:99]), .voxel_size(vsize_r), .occ_thr(othr_r),
    .free_thr(fthr_r), .dyn_life(life_r), .cell_state(st), .table_full(full)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) odata_r <= {full, st};
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, odata_r};
endmodule

// ===== rtl/voc_div.sv =====
`timescale 1ns / 1ps
// Signed floor division of a 32-bit value by a 31-bit positive divisor,
// one quotient bit per cycle.
module voc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [30:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [31:0] mag_r, mag_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] q_r, q_nxt;
  logic [30:0] d_r, d_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [31:0] qpos;

  always_comb begin
    mag_nxt = mag_r; rem_nxt = rem_r; q_nxt = q_r; d_nxt = d_r;
    neg_nxt = neg_r; cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, mag_r[31]} - {2'b0, d_r};
    qpos = q_r;
    if (start) begin
      neg_nxt  = num[31];
      mag_nxt  = num[31] ? (32'd0 - num) : num;
      d_nxt    = (den == 31'd0) ? 31'd1 : den;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt = {mag_r[30:0], 1'b0};
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], mag_r[31]};
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt; rem_r <= rem_nxt; q_r <= q_nxt; d_r <= d_nxt;
    neg_r <= neg_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Floor for negative numerators: -(q) less one when a remainder is left.
  assign done = done_r;
  assign quo  = !neg_r ? q_r : ((rem_r != 32'd0) ? (~q_r) : (32'd0 - q_r));
endmodule

// ===== rtl/voc_datapath.sv =====
`timescale 1ns / 1ps
module voc_datapath #(
  parameter int COUNT_WIDTH   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  voc_pkg::cmd_t      cmd,
  output voc_pkg::sts_t      sts,
  input  logic [2:0]         mode,
  input  logic [31:0]        pos_x,
  input  logic [31:0]        pos_y,
  input  logic [31:0]        pos_z,
  input  logic [31:0]        time_stamp,
  input  logic [30:0]        voxel_size,
  input  logic [15:0]        occ_thr,
  input  logic [15:0]        free_thr,
  input  logic [31:0]        dyn_life,
  output logic [1:0]         cell_state,
  output logic               table_full
);
  import voc_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int EW = 1 + 96 + 2 * COUNT_WIDTH + 33;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  logic [EW-1:0] mem [TABLE_ENTRIES];
  logic [EW-1:0] rd_r;

  logic [2:0]  mode_r;
  logic [31:0] px_r, py_r, pz_r, ts_r;
  logic [31:0] kx_r, ky_r, kz_r;
  logic [1:0]  ax_r;
  logic [AW-1:0] idx_r;
  logic [AW:0]   pcnt_r;
  logic [AW-1:0] ccnt_r;
  logic [1:0]    state_r;
  logic          full_r;

  logic        div_done;
  logic [31:0] quo;
  logic [31:0] div_num;
  logic [31:0] h1, h1_r, h2;

  always_comb begin
    case (ax_r)
      2'd0:    div_num = px_r;
      2'd1:    div_num = py_r;
      default: div_num = pz_r;
    endcase
  end

  voc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(div_num),
    .den(voxel_size), .done(div_done), .quo(quo)
  );

  // The x/y half of the hash is registered, so only the z half sits before idx_r.
  assign h1 = kx_r ^ (ky_r + HASH_MIX + (kx_r << 6) + (kx_r >> 2));
  assign h2 = h1_r ^ (kz_r + HASH_MIX + (h1_r << 6) + (h1_r >> 2));

  // Stored entry fields; the top bit marks the entry as used.
  logic eu;
  logic [31:0] ex, ey, ez, est;
  logic [COUNT_WIDTH-1:0] efc, eoc;
  logic edp;
  assign {eu, ex, ey, ez, efc, eoc, edp, est} = rd_r;

  // Entry after the update, from the read data or a fresh one.
  logic [31:0] nst;
  logic [COUNT_WIDTH-1:0] nfc, noc;
  logic ndp;
  logic [EW-1:0] wdata;
  logic [1:0] st_calc;
  logic [31:0] age;
  logic [15:0] ot, ft;

  always_comb begin
    if (eu) begin
      nfc = efc; noc = eoc; ndp = edp; nst = est;
    end else begin
      nfc = '0; noc = '0; ndp = 1'b0; nst = '0;
    end
    case (mode_r)
      MODE_FREE: if (nfc != CMAX) nfc = nfc + 1'b1;
      MODE_OCC:  if (noc != CMAX) noc = noc + 1'b1;
      MODE_DYN: begin
        if (!ndp || ts_r > nst) nst = ts_r;
        ndp = 1'b1;
      end
      default: ;
    endcase
    if (mode_r == MODE_QUERY) begin
      nfc = efc; noc = eoc; ndp = edp; nst = est;
    end
    wdata = {1'b1, kx_r, ky_r, kz_r, nfc, noc, ndp, nst};
    ot = (occ_thr == 16'd0) ? 16'd1 : occ_thr;
    ft = (free_thr == 16'd0) ? 16'd1 : free_thr;
    age = ts_r - nst;
    if (ndp && (ts_r <= nst || age <= dyn_life)) st_calc = 2'd2;
    else if (32'(noc) >= 32'(ot)) st_calc = 2'd2;
    else if (32'(nfc) >= 32'(ft)) st_calc = 2'd1;
    else st_calc = 2'd0;
  end

  // One write port: the clear sweep zeroes an entry per cycle, used flag included.
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  assign mem_we = cmd.clr || cmd.wr;
  assign mem_wa = cmd.clr ? ccnt_r : idx_r;
  assign mem_wd = cmd.clr ? '0 : wdata;

  always_ff @(posedge clk) begin
    h1_r <= h1;
    if (cmd.load) begin
      mode_r <= mode; px_r <= pos_x; py_r <= pos_y; pz_r <= pos_z; ts_r <= time_stamp;
      ax_r <= 2'd0;
    end
    if (div_done) begin
      case (ax_r)
        2'd0:    kx_r <= quo;
        2'd1:    ky_r <= quo;
        default: kz_r <= quo;
      endcase
      ax_r <= ax_r + 2'd1;
    end
    if (cmd.hash) begin
      idx_r  <= h2[AW-1:0];
      pcnt_r <= '0;
    end
    if (cmd.step) begin
      idx_r  <= idx_r + 1'b1;
      pcnt_r <= pcnt_r + 1'b1;
    end
    if (cmd.rd) rd_r <= mem[idx_r];
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.res) begin
      if (mode_r > MODE_CLEAR || mode_r == MODE_CLEAR) begin
        state_r <= 2'd0; full_r <= 1'b0;
      end else if (mode_r == MODE_QUERY) begin
        state_r <= (eu && !sts.exhausted) ? st_calc : 2'd0;
        full_r  <= 1'b0;
      end else if (sts.exhausted) begin
        state_r <= 2'd0; full_r <= 1'b1;
      end else begin
        state_r <= st_calc; full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r <= '0;
    end else if (cmd.clr) begin
      ccnt_r <= ccnt_r + 1'b1;
    end else begin
      ccnt_r <= '0;
    end
  end

  assign sts.div_done  = div_done;
  assign sts.last_axis = ax_r == 2'd2;
  assign sts.hit       = eu && ex == kx_r && ey == ky_r && ez == kz_r;
  assign sts.empty     = !eu;
  assign sts.exhausted = pcnt_r == (AW+1)'(TABLE_ENTRIES);
  assign sts.clr_done  = ccnt_r == AW'(TABLE_ENTRIES - 1);
  assign cell_state    = state_r;
  assign table_full    = full_r;
endmodule

// ===== rtl/voc_ctrl.sv =====
`timescale 1ns / 1ps
module voc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic [2:0]    in_mode,
  input  logic          out_busy,
  input  logic          out_taken,
  input  voc_pkg::sts_t sts,
  output voc_pkg::cmd_t cmd,
  output logic          in_ready,
  output logic          out_load
);
  import voc_pkg::*;

  state_t state_r, state_nxt;
  logic   mode_upd_r;
  logic   clr_res_r;

  // A clear sweep after reset gives no result; one after a clear-all does.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      mode_upd_r <= 1'b0;
      clr_res_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        mode_upd_r <= (in_mode < MODE_QUERY);
        clr_res_r  <= (in_mode == MODE_CLEAR);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = clr_res_r ? ST_UPD : ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          if (in_mode == MODE_CLEAR) state_nxt = ST_CLEAR;
          else if (in_mode > MODE_CLEAR) state_nxt = ST_UPD;
          else state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.div_done) state_nxt = sts.last_axis ? ST_HASH : ST_DIV;
      end
      ST_HASH: begin
        cmd.hash = 1'b1;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.exhausted || sts.hit || sts.empty) begin
          state_nxt = ST_UPD;
        end else begin
          cmd.step = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_UPD: begin
        cmd.res = 1'b1;
        cmd.wr  = mode_upd_r && !sts.exhausted;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy || out_taken) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/voc_checker.sv =====
`timescale 1ns / 1ps
module voc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3 && out_tdata[7:3] == 5'd0)
    else $error("bad result code");
  a_full_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == 2'd0)
    else $error("dropped insert with known state");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");
endmodule

bind voxel_occupancy_cell_store voc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
